### rtl/tpm_pkg.sv
`timescale 1ns / 1ps

package tpm_pkg;

	// fixed field widths
	localparam int CMD_W      = 3;
	localparam int PFN_W      = 20;
	localparam int ADDR_W     = 32;
	localparam int SLOT_OUT_W = 6;
	localparam int ASLOT_W    = 7;
	localparam int STAT_W     = 3;

	// command codes
	localparam logic [CMD_W-1:0] CMD_MAP          = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNMAP_ADDR   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UNMAP_FRAME  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ATOMIC_MAP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ATOMIC_UNMAP = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FREE  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NO_FRAME = 3'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd3;
	localparam logic [STAT_W-1:0] STAT_IGNORED  = 3'd4;

	// sequencer -> slot scan unit
	typedef struct packed {
		logic start;     // begin a scan over the live slots
		logic by_frame;  // 1: look for busy slot holding pfn, 0: look for free slot
		logic clr;       // free the slot at clr_idx
	} scan_req_t;

	// slot scan unit -> sequencer
	typedef struct packed {
		logic done;      // scan finished this cycle
		logic found;     // a slot matched
	} scan_rsp_t;

endpackage

### rtl/tpm_addr_alu.sv
`timescale 1ns / 1ps

// Shared 32-bit add/subtract unit.
module tpm_addr_alu (
	input  logic [tpm_pkg::ADDR_W-1:0] a,
	input  logic [tpm_pkg::ADDR_W-1:0] b,
	input  logic                       sub,
	output logic [tpm_pkg::ADDR_W-1:0] sum
);

	assign sum = sub ? (a - b) : (a + b);

endmodule

### rtl/tpm_slot_scan.sv
`timescale 1ns / 1ps

// Live slot state plus a one-slot-per-cycle scanner.
// Frame store has a registered read; compare happens in the cycle after the read.
module tpm_slot_scan #(
	parameter int LIVE_SLOTS = 16,
	localparam int LIVE_W = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tpm_pkg::scan_req_t        req,
	input  logic [tpm_pkg::PFN_W-1:0] pfn,
	input  logic [LIVE_W-1:0]         clr_idx,
	output tpm_pkg::scan_rsp_t        rsp,
	output logic [LIVE_W-1:0]         hit_idx
);

	logic [LIVE_SLOTS-1:0]     busy_q;
	logic [tpm_pkg::PFN_W-1:0] frame_mem [LIVE_SLOTS];

	logic                      run_q;
	logic                      by_frame_q;
	logic [LIVE_W-1:0]         cnt_q;
	logic                      chk_s1;
	logic                      last_s1;
	logic                      busy_s1;
	logic [LIVE_W-1:0]         idx_s1;
	logic [tpm_pkg::PFN_W-1:0] rd_s1;

	logic cnt_last;
	logic hit;

	assign cnt_last = (cnt_q == LIVE_W'(LIVE_SLOTS - 1));
	assign hit      = chk_s1 && (by_frame_q ? (busy_s1 && (rd_s1 == pfn)) : !busy_s1);

	assign rsp.done  = hit || (chk_s1 && last_s1);
	assign rsp.found = hit;
	assign hit_idx   = idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			by_frame_q <= 1'b0;
			cnt_q      <= '0;
			chk_s1     <= 1'b0;
		end else if (req.start) begin
			run_q      <= 1'b1;
			by_frame_q <= req.by_frame;
			cnt_q      <= '0;
			chk_s1     <= 1'b0;
		end else if (hit) begin
			run_q  <= 1'b0;
			chk_s1 <= 1'b0;
		end else begin
			chk_s1 <= run_q;
			if (run_q) begin
				if (cnt_last) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// busy bits: set on map hit, cleared on frame hit or direct free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			if (hit) begin
				busy_q[idx_s1] <= !by_frame_q;
			end
			if (req.clr) begin
				busy_q[clr_idx] <= 1'b0;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q;
		last_s1 <= cnt_last;
		busy_s1 <= busy_q[cnt_q];
	end

	// frame store
	always_ff @(posedge clk) begin
		rd_s1 <= frame_mem[cnt_q];
		if (hit && !by_frame_q) begin
			frame_mem[idx_s1] <= pfn;
		end
	end

endmodule

### rtl/temp_page_map_slot_allocator.sv
`timescale 1ns / 1ps

// Temporary page-mapping slot allocator. Takes one command word at a time and
// returns one result word per command. Map and unmap-by-frame walk the live
// slots one per cycle through the slot scan unit (registered frame read, then
// compare), stopping early when a slot matches. Unmap by address, the atomic
// commands and unused codes skip the scan and go through decode, address, load.
// All address math (kva - base, base + slot << PAGE_SHIFT) runs through one
// shared 32-bit adder. A new command is taken as soon as the sequencer is
// idle, even while the previous result still waits in the output register.
// No clearing pass after reset; the block is ready as soon as reset is released.
// The user must write window_base through cfg_we/cfg_wdata only while idle; the block does not enforce it.
module temp_page_map_slot_allocator #(
	parameter int LIVE_SLOTS   = 16,
	parameter int NORMAL_SLOTS = 32,
	parameter int ATOMIC_SLOTS = 8,
	parameter int PAGE_SHIFT   = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_we,
	input  logic [tpm_pkg::ADDR_W-1:0]  cfg_wdata,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tpm_pkg::CMD_W-1:0]   cmd,
	input  logic [tpm_pkg::PFN_W-1:0]   pfn,
	input  logic [tpm_pkg::ADDR_W-1:0]  kva,
	input  logic signed [tpm_pkg::ASLOT_W-1:0] atomic_slot,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tpm_pkg::STAT_W-1:0]  status,
	output logic [tpm_pkg::SLOT_OUT_W-1:0] slot_index,
	output logic [tpm_pkg::ADDR_W-1:0]  map_address,
	output logic                        pte_write,
	output logic                        pte_valid,
	output logic [tpm_pkg::PFN_W-1:0]   pte_pfn
);

	localparam int WIN_SLOTS = NORMAL_SLOTS + ATOMIC_SLOTS;
	localparam int MAX_SLOTS = (LIVE_SLOTS > WIN_SLOTS) ? LIVE_SLOTS : WIN_SLOTS;
	localparam int IDX_W     = $clog2(MAX_SLOTS + 1);
	localparam int LIVE_W    = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;
	localparam int PTR_W     = (ATOMIC_SLOTS > 1) ? $clog2(ATOMIC_SLOTS) : 1;
	localparam int AW        = tpm_pkg::ADDR_W;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_ADDR   = 3'd3;

	logic [2:0]                   state_q;
	logic [AW-1:0]                base_q;
	logic [PTR_W-1:0]             ptr_q;

	// latched command word
	logic [tpm_pkg::CMD_W-1:0]    cmd_q;
	logic [tpm_pkg::PFN_W-1:0]    pfn_q;
	logic [AW-1:0]                kva_q;
	logic [tpm_pkg::ASLOT_W-1:0]  araw_q;

	// result being built
	logic [tpm_pkg::STAT_W-1:0]   stat_q;
	logic [IDX_W-1:0]             idx_q;
	logic                         wr_q;
	logic                         val_q;

	// output register
	logic                         out_valid_q;
	logic [tpm_pkg::STAT_W-1:0]   status_q;
	logic [tpm_pkg::SLOT_OUT_W-1:0] slot_index_q;
	logic [AW-1:0]                map_address_q;
	logic                         pte_write_q;
	logic                         pte_valid_q;
	logic [tpm_pkg::PFN_W-1:0]    pte_pfn_q;

	// shared adder
	logic [AW-1:0] alu_a, alu_b, alu_sum;
	logic          alu_sub;
	logic [AW-1:0] idx_ext;

	// scan unit
	tpm_pkg::scan_req_t scan_req;
	tpm_pkg::scan_rsp_t scan_rsp;
	logic [LIVE_W-1:0]  hit_idx;
	logic [AW-1:0]      hit_ext;

	// decode helpers
	logic [AW-1:0] diff_idx;
	logic          addr_in_range;
	logic [AW-1:0] araw_ext;
	logic [AW-1:0] atomic_idx;
	logic          out_free;
	logic          accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign idx_ext = {{(AW - IDX_W){1'b0}}, idx_q};
	assign hit_ext = {{(AW - LIVE_W){1'b0}}, hit_idx};

	// decode cycle subtracts, address cycle adds
	assign alu_sub = (state_q == S_DECODE);
	assign alu_a   = alu_sub ? kva_q : base_q;
	assign alu_b   = alu_sub ? base_q : (idx_ext << PAGE_SHIFT);

	tpm_addr_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.sum (alu_sum)
	);

	assign diff_idx      = alu_sum >> PAGE_SHIFT;
	assign addr_in_range = (diff_idx < AW'(LIVE_SLOTS));

	// sign bit handled separately; this is the magnitude only
	assign araw_ext   = {{(AW - tpm_pkg::ASLOT_W + 1){1'b0}}, araw_q[tpm_pkg::ASLOT_W-2:0]};
	assign atomic_idx = AW'(NORMAL_SLOTS) + {{(AW - PTR_W){1'b0}}, ptr_q};

	always_comb begin
		scan_req.start    = 1'b0;
		scan_req.by_frame = (cmd_q == tpm_pkg::CMD_UNMAP_FRAME);
		scan_req.clr      = 1'b0;
		if (state_q == S_DECODE) begin
			scan_req.start = (cmd_q == tpm_pkg::CMD_MAP) ||
			                 (cmd_q == tpm_pkg::CMD_UNMAP_FRAME);
			scan_req.clr   = (cmd_q == tpm_pkg::CMD_UNMAP_ADDR) && addr_in_range;
		end
	end

	tpm_slot_scan #(
		.LIVE_SLOTS (LIVE_SLOTS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (scan_req),
		.pfn     (pfn_q),
		.clr_idx (diff_idx[LIVE_W-1:0]),
		.rsp     (scan_rsp),
		.hit_idx (hit_idx)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (scan_req.start) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_ADDR;
					end
					if (cmd_q == tpm_pkg::CMD_ATOMIC_MAP) begin
						ptr_q <= (ptr_q == PTR_W'(ATOMIC_SLOTS - 1)) ? '0 : ptr_q + 1'b1;
					end
				end
				S_SCAN: begin
					if (scan_rsp.done) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command latch and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			pfn_q  <= pfn;
			kva_q  <= kva;
			araw_q <= atomic_slot;
		end
		if (state_q == S_DECODE) begin
			stat_q <= tpm_pkg::STAT_IGNORED;
			idx_q  <= '0;
			wr_q   <= 1'b0;
			val_q  <= 1'b0;
			case (cmd_q)
				tpm_pkg::CMD_UNMAP_ADDR: begin
					if (addr_in_range) begin
						stat_q <= tpm_pkg::STAT_OK;
						idx_q  <= diff_idx[IDX_W-1:0];
						wr_q   <= 1'b1;
					end else begin
						stat_q <= tpm_pkg::STAT_RANGE;
					end
				end
				tpm_pkg::CMD_ATOMIC_MAP: begin
					stat_q <= tpm_pkg::STAT_OK;
					idx_q  <= atomic_idx[IDX_W-1:0];
					wr_q   <= 1'b1;
					val_q  <= 1'b1;
				end
				tpm_pkg::CMD_ATOMIC_UNMAP: begin
					if (araw_q[tpm_pkg::ASLOT_W-1]) begin
						stat_q <= tpm_pkg::STAT_IGNORED;
					end else if (araw_ext >= AW'(WIN_SLOTS)) begin
						stat_q <= tpm_pkg::STAT_RANGE;
					end else begin
						stat_q <= tpm_pkg::STAT_OK;
						idx_q  <= araw_ext[IDX_W-1:0];
						wr_q   <= 1'b1;
					end
				end
				default: begin
					// map / unmap by frame resolve in the scan; unused codes stay ignored
				end
			endcase
		end else if ((state_q == S_SCAN) && scan_rsp.done) begin
			if (scan_rsp.found) begin
				stat_q <= tpm_pkg::STAT_OK;
				idx_q  <= hit_ext[IDX_W-1:0];
				wr_q   <= 1'b1;
				val_q  <= !scan_req.by_frame;
			end else begin
				stat_q <= scan_req.by_frame ? tpm_pkg::STAT_NO_FRAME : tpm_pkg::STAT_NO_FREE;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_ADDR) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_ADDR) && out_free) begin
			status_q      <= stat_q;
			slot_index_q  <= wr_q ? idx_ext[tpm_pkg::SLOT_OUT_W-1:0] : '0;
			map_address_q <= wr_q ? alu_sum : '0;
			pte_write_q   <= wr_q;
			pte_valid_q   <= wr_q && val_q;
			pte_pfn_q     <= (wr_q && val_q) ? pfn_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot_index  = slot_index_q;
	assign map_address = map_address_q;
	assign pte_write   = pte_write_q;
	assign pte_valid   = pte_valid_q;
	assign pte_pfn     = pte_pfn_q;

	// a scan can only finish while the sequencer waits on it
	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_rsp.done |-> (state_q == S_SCAN))
		else $error("scan finished outside scan state");

	// an accepted word always goes to decode next
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DECODE))
		else $error("accepted word not decoded");

	// only a successful command rewrites an entry
	a_ok_means_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((status_q == tpm_pkg::STAT_OK) == pte_write_q))
		else $error("status and pte write disagree");

	// a new result is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(map_address_q))
		else $error("pending result overwritten");

endmodule
